// ===== hdl/srrw_pkg.sv =====
// srrw_pkg: shared constants, payload structs and controller/datapath
// command and status types for the selective-repeat receive window
// no dependencies
`default_nettype none

package srrw_pkg;

    localparam int FRAME_BYTES   = 1024;
    localparam int WINDOW_FRAMES = 32;
    localparam int MAX_RESULTS   = 32;

    localparam int FS_W     = 24;
    localparam int OFF_W    = 24;
    localparam int LEN_W    = 11;
    localparam int KIND_W   = 2;
    localparam int OSLOT_W  = 5;

    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int FRAME_W     = FS_W - FRAME_SHIFT + 1;
    localparam int SLOT_W      = $clog2(WINDOW_FRAMES);
    localparam int SUM_W       = SLOT_W + 1;
    localparam int IDX_W       = $clog2(WINDOW_FRAMES + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // register index, taken from the word address
    localparam logic REG_TOTAL_BYTES = 1'b0;

    localparam logic [KIND_W-1:0] KIND_RESP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    localparam logic RES_REQUEST = 1'b0;
    localparam logic RES_RELEASE = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  start_offset;
        logic [LEN_W-1:0]  data_length;
    } item_t;

    typedef struct packed {
        logic               result_kind;
        logic [OFF_W-1:0]   byte_offset;
        logic [LEN_W-1:0]   frame_bytes;
        logic [OSLOT_W-1:0] window_slot;
        logic               last;
        logic               all_done;
    } result_t;

    typedef struct packed {
        logic accept;
        logic resp_apply;
        logic step_start;
        logic step_rel;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic start_end;
        logic rel_hit;
        logic cand_valid;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/srrw_ctrl.sv =====
// srrw_ctrl: sequencer for the receive window, issues datapath commands
// depends on srrw_pkg
`default_nettype none

module srrw_ctrl
    import srrw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic [KIND_W-1:0] item_kind,
    output logic                   item_stall,
    input  wire status_t           status,
    output cmd_t                   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_SCAN_START,
        S_SCAN_REL,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;
    logic   can_step;

    assign item_stall = stall_reg;
    // a step may hand the held candidate to the output register
    assign can_step = status.out_free || !status.cand_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (item_kind)
                        KIND_RESP:  state_next = S_RESP;
                        KIND_START: state_next = S_SCAN_START;
                        KIND_END:   state_next = S_SCAN_REL;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_RESP:
            begin
                cmd.resp_apply = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCAN_START:
            begin
                if (status.start_end)
                    state_next = S_FLUSH;
                else if (can_step)
                    cmd.step_start = 1'b1;
            end
            S_SCAN_REL:
            begin
                if (!status.rel_hit)
                    state_next = S_FLUSH;
                else if (can_step)
                    cmd.step_rel = 1'b1;
            end
            S_FLUSH:
            begin
                if (!status.cand_valid)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/srrw_datapath.sv =====
// srrw_datapath: window state, arrival flags, stored lengths, scan counters,
// candidate holding register and output register
// depends on srrw_pkg
`default_nettype none

module srrw_datapath
    import srrw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    output status_t               status,
    input  wire item_t            item,
    input  wire logic             cfg_we,
    input  wire logic [FS_W-1:0]  cfg_data,
    output logic [FS_W-1:0]       total_bytes,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result
);

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SUM_W'(WINDOW_FRAMES))
            s = s - SUM_W'(WINDOW_FRAMES);
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [OFF_W-1:0] frame_offset(input logic [FRAME_W-1:0] f);
        logic [FRAME_W+FRAME_SHIFT-1:0] wide;
        wide = {f, {FRAME_SHIFT{1'b0}}};
        return OFF_W'(wide);
    endfunction

    logic [FS_W-1:0]          total_bytes_reg;
    logic [FRAME_W-1:0]       remaining_reg;
    logic [FRAME_W-1:0]       released_reg;
    logic [SLOT_W-1:0]        head_reg;
    logic [WINDOW_FRAMES-1:0] arrived_reg;
    logic [LEN_W-1:0]         len_reg [WINDOW_FRAMES];
    logic [LEN_W-1:0]         last_len_reg;
    item_t                    item_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     cand_valid_reg;
    result_t                  cand_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic [IDX_W-1:0]         win_size;
    logic [FRAME_W-1:0]       cfg_frames;
    logic [FRAME_SHIFT-1:0]   cfg_rem;
    logic [FRAME_W-1:0]       resp_frame;
    logic [FRAME_W-1:0]       resp_diff;
    logic                     resp_in_win;
    logic [SLOT_W-1:0]        resp_slot;
    logic [SLOT_W-1:0]        scan_slot;
    logic                     start_hit;
    logic                     cap_hit;
    logic [FRAME_W-1:0]       req_frame;
    logic                     req_is_last;
    result_t                  req_res;
    result_t                  rel_res;
    logic                     push;
    result_t                  push_res;

    assign total_bytes  = total_bytes_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // remaining frames capped at the window size
    assign win_size = (remaining_reg < FRAME_W'(WINDOW_FRAMES)) ? IDX_W'(remaining_reg)
                                                                : IDX_W'(WINDOW_FRAMES);

    assign cfg_rem    = cfg_data[FRAME_SHIFT-1:0];
    assign cfg_frames = FRAME_W'(cfg_data >> FRAME_SHIFT) + FRAME_W'(cfg_rem != '0);

    // response lookup
    assign resp_frame  = FRAME_W'(item_reg.start_offset >> FRAME_SHIFT);
    assign resp_diff   = resp_frame - released_reg;
    assign resp_in_win = (resp_frame >= released_reg) && (resp_diff < FRAME_W'(win_size));
    assign resp_slot   = slot_add(head_reg, resp_diff[SLOT_W-1:0]);

    // round start scan
    assign cap_hit     = (cnt_reg == CNT_W'(MAX_RESULTS));
    assign scan_slot   = slot_add(head_reg, idx_reg[SLOT_W-1:0]);
    assign start_hit   = !arrived_reg[scan_slot];
    assign req_frame   = released_reg + FRAME_W'(idx_reg);
    assign req_is_last = (FRAME_W'(idx_reg) + FRAME_W'(1)) == remaining_reg;

    always_comb
    begin
        req_res.result_kind = RES_REQUEST;
        req_res.byte_offset = frame_offset(req_frame);
        req_res.frame_bytes = req_is_last ? last_len_reg : LEN_W'(FRAME_BYTES);
        req_res.window_slot = OSLOT_W'(scan_slot);
        req_res.last        = 1'b0;
        req_res.all_done    = 1'b0;

        rel_res.result_kind = RES_RELEASE;
        rel_res.byte_offset = frame_offset(released_reg);
        rel_res.frame_bytes = len_reg[head_reg];
        rel_res.window_slot = OSLOT_W'(head_reg);
        rel_res.last        = 1'b0;
        rel_res.all_done    = (remaining_reg == FRAME_W'(1));
    end

    always_comb
    begin
        status.start_end  = (idx_reg >= win_size) || cap_hit;
        status.rel_hit    = (remaining_reg != '0) && arrived_reg[head_reg] && !cap_hit;
        status.cand_valid = cand_valid_reg;
        status.out_free   = !out_valid_reg || !result_stall;
    end

    // older candidate moves out when a newer one is found, or on flush
    always_comb
    begin
        push     = 1'b0;
        push_res = cand_reg;
        if (cmd.flush)
        begin
            push          = 1'b1;
            push_res.last = 1'b1;
        end
        else if (cand_valid_reg && (cmd.step_rel || (cmd.step_start && start_hit)))
            push = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_bytes_reg <= '0;
            remaining_reg   <= '0;
            released_reg    <= '0;
            head_reg        <= '0;
            arrived_reg     <= '0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            cand_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_bytes_reg <= cfg_data;
                remaining_reg   <= cfg_frames;
                released_reg    <= '0;
                head_reg        <= '0;
                arrived_reg     <= '0;
            end
            else if (cmd.resp_apply)
            begin
                if (resp_in_win)
                    arrived_reg[resp_slot] <= 1'b1;
            end
            else if (cmd.step_rel)
            begin
                arrived_reg[head_reg] <= 1'b0;
                released_reg          <= released_reg + FRAME_W'(1);
                remaining_reg         <= remaining_reg - FRAME_W'(1);
                head_reg              <= slot_add(head_reg, SLOT_W'(1));
            end

            if (cmd.accept)
            begin
                idx_reg <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.step_start)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (start_hit)
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.step_rel)
                cnt_reg <= cnt_reg + CNT_W'(1);

            if (cmd.flush)
                cand_valid_reg <= 1'b0;
            else if (cmd.step_rel || (cmd.step_start && start_hit))
                cand_valid_reg <= 1'b1;

            if (push)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cfg_we)
            last_len_reg <= (cfg_rem != '0) ? LEN_W'(cfg_rem) : LEN_W'(FRAME_BYTES);
        if (cmd.accept)
            item_reg <= item;
        if (cmd.resp_apply && resp_in_win && !arrived_reg[resp_slot])
            len_reg[resp_slot] <= item_reg.data_length;
        if (cmd.step_rel)
            cand_reg <= rel_res;
        else if (cmd.step_start && start_hit)
            cand_reg <= req_res;
        if (push)
            out_reg <= push_res;
    end

endmodule

`default_nettype wire

// ===== hdl/selective_repeat_receive_window_top.sv =====
// selective_repeat_receive_window_top: top level of the receive window,
// register port decode plus sequencer and datapath
// depends on srrw_pkg, srrw_ctrl, srrw_datapath
`default_nettype none

// Receiver-side selective-repeat window over a file cut into FRAME_BYTES
// frames, WINDOW_FRAMES frames wide. Write the total byte count (byte address
// 0) while the block is idle; the write restarts the transfer. An item beat of
// kind response marks its frame arrived when it lies in the window and is new,
// keeping its length; it yields nothing, and the next item beat is taken once
// the sequencer has applied it. A round start walks the window one slot per
// cycle while the result side can take the held candidate, and yields one
// request beat per missing frame; after the walk ends, the final result is
// handed to the output register before the next item beat is taken. A round
// end releases arrived frames at the window front one per cycle while the
// result side can take the held candidate, each with its ring slot and stored
// length, and slides the window. A stalled result side holds either walk.
// The final result of an item carries last, and all_done marks the release of
// the file's final frame. item_stall stays high from acceptance until the
// item's last result sits in the output register, or until the sequencer is
// idle again when the item yields no result.
module selective_repeat_receive_window_top
    import srrw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cmd_t            cmd;
    status_t         status;
    logic            cfg_we;
    logic            sel_total_bytes;
    logic [FS_W-1:0] total_bytes;

    // one register at word 0, higher words read as zero and ignore writes
    assign sel_total_bytes = (paddr[2] == REG_TOTAL_BYTES);
    assign cfg_we          = psel && penable && pwrite && sel_total_bytes;
    assign pready          = 1'b1;
    assign prdata          = sel_total_bytes ? 32'(total_bytes) : 32'd0;

    srrw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    srrw_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (pwdata[FS_W-1:0]),
        .total_bytes  (total_bytes),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
